// File: hw/rtl/amo_pkg.sv
// ----------------------------------------------------------------------------
// Atomic memory operation unit: shared package
// Transaction layouts, operation and size codes, and the command and status
// structs that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package amo_pkg;

    // Request field widths.
    localparam int MODE_W    = 3;
    localparam int SIZE_W    = 2;
    localparam int ADDR_W    = 12;
    localparam int DATA_W    = 32;
    // Word index taken from the byte address (address divided by four).
    localparam int WIDX_W    = ADDR_W - 2;

    // Request transaction layout, lowest bit first.
    localparam int REQ_MODE_LSB = 0;
    localparam int REQ_SIZE_LSB = REQ_MODE_LSB + MODE_W;
    localparam int REQ_RNEW_LSB = REQ_SIZE_LSB + SIZE_W;
    localparam int REQ_ADDR_LSB = REQ_RNEW_LSB + 1;
    localparam int REQ_OPND_LSB = REQ_ADDR_LSB + ADDR_W;
    localparam int REQ_EXPV_LSB = REQ_OPND_LSB + DATA_W;
    localparam int REQ_BITS     = REQ_EXPV_LSB + DATA_W;
    localparam int REQ_TDATA_W  = ((REQ_BITS + 7) / 8) * 8;

    // Response transaction layout: value, then the swapped flag.
    localparam int RSP_BITS     = DATA_W + 1;
    localparam int RSP_TDATA_W  = ((RSP_BITS + 7) / 8) * 8;

    // Operation codes.
    localparam logic [MODE_W-1:0] OP_ADD  = 3'd0;
    localparam logic [MODE_W-1:0] OP_SUB  = 3'd1;
    localparam logic [MODE_W-1:0] OP_OR   = 3'd2;
    localparam logic [MODE_W-1:0] OP_AND  = 3'd3;
    localparam logic [MODE_W-1:0] OP_XOR  = 3'd4;
    localparam logic [MODE_W-1:0] OP_NAND = 3'd5;
    localparam logic [MODE_W-1:0] OP_XCHG = 3'd6;
    localparam logic [MODE_W-1:0] OP_CAS  = 3'd7;

    // Access size codes; any other code is a word access.
    localparam logic [SIZE_W-1:0] SZ_BYTE = 2'd0;
    localparam logic [SIZE_W-1:0] SZ_HALF = 2'd1;

    // Big-endian lane placement.
    localparam logic [4:0] BYTE_SHIFT_FLIP = 5'd24;
    localparam logic [4:0] HALF_SHIFT_FLIP = 5'd16;
    localparam logic [DATA_W-1:0] BYTE_MASK = 32'h0000_00ff;
    localparam logic [DATA_W-1:0] HALF_MASK = 32'h0000_ffff;

    // Controller to datapath commands.
    typedef struct packed {
        logic clr_wr;    // write zero at the clearing pointer
        logic req_load;  // capture the accepted request
        logic rd_en;     // read the addressed word
        logic rmw_wr;    // write back the modified word
        logic out_load;  // load the response register
    } t_amo_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic clr_last;  // clearing pointer is at the last word
    } t_amo_sts;

endpackage

// File: hw/rtl/amo_ctrl.sv
// ----------------------------------------------------------------------------
// Atomic memory operation unit: controller
// Sequences the clearing pass after reset and the accept, read and
// read-modify-write steps of each request, and owns the response valid flag.
// ----------------------------------------------------------------------------
module amo_ctrl
    import amo_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    output logic     o_req_ready,
    output logic     o_rsp_valid,
    input  logic     i_rsp_ready,
    input  t_amo_sts i_sts,
    output t_amo_cmd o_cmd
);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_READ   = 2'd2;
    localparam logic [1:0] ST_MODIFY = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_rsp_valid;
    logic       n_rsp_valid;
    logic       rsp_free;
    logic       req_fire;

    // The response register can take a new result when it is empty or drains now.
    assign rsp_free = !r_rsp_valid || i_rsp_ready;
    assign req_fire = i_req_valid && (r_state == ST_IDLE);

    // Next-state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (req_fire) begin
                    o_cmd.req_load = 1'b1;
                    n_state        = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = ST_MODIFY;
            end
            ST_MODIFY: begin
                if (rsp_free) begin
                    o_cmd.rmw_wr   = 1'b1;
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Response valid: set on load, cleared when the receiver takes it.
    always_comb begin
        n_rsp_valid = r_rsp_valid;
        if (o_cmd.out_load) begin
            n_rsp_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_req_ready = (r_state == ST_IDLE);
    assign o_rsp_valid = r_rsp_valid;

    // An accepted request always goes on to read its word.
    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_fire |=> (r_state == ST_READ))
        else $error("accepted request did not move to the read step");

    // A result never overwrites one the receiver has not yet taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> rsp_free)
        else $error("response register overwritten while stalled");

    // The write-back and the response load happen together.
    a_write_with_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rmw_wr |-> o_cmd.out_load)
        else $error("write-back without a response");

    // The clearing pass ends at the last word and opens the input.
    a_clear_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR && i_sts.clr_last) |=> (r_state == ST_IDLE))
        else $error("clearing pass did not end at the last word");

endmodule

// File: hw/rtl/amo_dp.sv
// ----------------------------------------------------------------------------
// Atomic memory operation unit: datapath
// Holds the word store, the request registers, the word index reduction,
// the lane extract and ALU, and the response payload register.
// ----------------------------------------------------------------------------
module amo_dp
    import amo_pkg::*;
#(
    parameter int STORE_WORDS = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [REQ_TDATA_W-1:0] i_req_data,
    input  t_amo_cmd               i_cmd,
    output t_amo_sts               o_sts,
    output logic [DATA_W-1:0]      o_value,
    output logic                   o_swapped
);

    localparam int IDX_W = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    // Floor reciprocal scaled by the index range; exact to within one.
    localparam int RECIP = (1 << WIDX_W) / STORE_WORDS;
    localparam int RCP_W = WIDX_W + 1;
    localparam int PRD_W = WIDX_W + RCP_W;
    localparam int QS_W  = 31;
    localparam logic [RCP_W-1:0] RECIP_V = RCP_W'(RECIP);
    localparam logic [QS_W-1:0]  WORDS_V = QS_W'(STORE_WORDS);
    localparam logic [IDX_W-1:0] LAST_V  = IDX_W'(STORE_WORDS - 1);

    logic [DATA_W-1:0] mem [STORE_WORDS];

    logic [MODE_W-1:0] r_mode;
    logic [SIZE_W-1:0] r_size;
    logic              r_rnew;
    logic [ADDR_W-1:0] r_addr;
    logic [DATA_W-1:0] r_opnd;
    logic [DATA_W-1:0] r_expv;
    logic [WIDX_W-1:0] r_quot;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_clr_idx;
    logic [DATA_W-1:0] r_rd_word;
    logic [DATA_W-1:0] r_value;
    logic              r_swapped;

    logic [WIDX_W-1:0] in_widx;
    logic [PRD_W-1:0]  in_prod;
    logic [QS_W-1:0]   q_times_n;
    logic [QS_W-1:0]   diff;
    logic [QS_W-1:0]   rem;
    logic [IDX_W-1:0]  rd_idx;

    logic [4:0]        shift;
    logic [DATA_W-1:0] lane_mask;
    logic [DATA_W-1:0] old_lane;
    logic [DATA_W-1:0] opnd_lane;
    logic [DATA_W-1:0] alu_out;
    logic [DATA_W-1:0] new_lane;
    logic [DATA_W-1:0] new_word;
    logic [DATA_W-1:0] result;
    logic              cas_match;
    logic              do_write;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa;
    logic [DATA_W-1:0] mem_wd;

    // Quotient estimate of the word index by the store depth, from the input.
    assign in_widx = i_req_data[REQ_ADDR_LSB+2 +: WIDX_W];
    assign in_prod = PRD_W'(in_widx) * PRD_W'(RECIP_V);

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.req_load) begin
            r_mode <= i_req_data[REQ_MODE_LSB +: MODE_W];
            r_size <= i_req_data[REQ_SIZE_LSB +: SIZE_W];
            r_rnew <= i_req_data[REQ_RNEW_LSB];
            r_addr <= i_req_data[REQ_ADDR_LSB +: ADDR_W];
            r_opnd <= i_req_data[REQ_OPND_LSB +: DATA_W];
            r_expv <= i_req_data[REQ_EXPV_LSB +: DATA_W];
            r_quot <= in_prod[WIDX_W +: WIDX_W];
        end
    end

    // Remainder of the word index: one subtract of the product, one correction.
    assign q_times_n = QS_W'(r_quot) * WORDS_V;
    assign diff      = QS_W'(r_addr[ADDR_W-1:2]) - q_times_n;
    assign rem       = (diff >= WORDS_V) ? (diff - WORDS_V) : diff;
    assign rd_idx    = IDX_W'(rem);

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_idx <= rd_idx;
        end
    end

    // Clearing pointer for the pass after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_idx <= r_clr_idx + IDX_W'(1);
        end
    end

    assign o_sts.clr_last = (r_clr_idx == LAST_V);

    // Lane placement, big-endian within the word.
    always_comb begin
        case (r_size)
            SZ_BYTE: begin
                shift     = {r_addr[1:0], 3'b000} ^ BYTE_SHIFT_FLIP;
                lane_mask = BYTE_MASK;
            end
            SZ_HALF: begin
                shift     = {r_addr[1], 4'b0000} ^ HALF_SHIFT_FLIP;
                lane_mask = HALF_MASK;
            end
            default: begin
                shift     = 5'd0;
                lane_mask = '1;
            end
        endcase
    end

    assign old_lane  = (r_rd_word >> shift) & lane_mask;
    assign opnd_lane = r_opnd & lane_mask;
    assign cas_match = (old_lane == (r_expv & lane_mask));

    // Lane ALU; exchange and compare-and-swap pass the operand through.
    always_comb begin
        case (r_mode)
            OP_ADD:  alu_out = old_lane + opnd_lane;
            OP_SUB:  alu_out = old_lane - opnd_lane;
            OP_OR:   alu_out = old_lane | opnd_lane;
            OP_AND:  alu_out = old_lane & opnd_lane;
            OP_XOR:  alu_out = old_lane ^ opnd_lane;
            OP_NAND: alu_out = ~(old_lane & opnd_lane);
            default: alu_out = opnd_lane;
        endcase
    end

    assign new_lane = alu_out & lane_mask;
    assign new_word = (r_rd_word & ~(lane_mask << shift)) | (new_lane << shift);
    assign do_write = (r_mode != OP_CAS) || cas_match;
    assign result   = ((r_mode == OP_XCHG) || (r_mode == OP_CAS) || !r_rnew)
                      ? old_lane : new_lane;

    // Word store: one write port, one registered read port.
    assign mem_we = i_cmd.clr_wr || (i_cmd.rmw_wr && do_write);
    assign mem_wa = i_cmd.clr_wr ? r_clr_idx : r_idx;
    assign mem_wd = i_cmd.clr_wr ? '0 : new_word;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.rd_en) begin
            r_rd_word <= mem[rd_idx];
        end
    end

    // Response payload register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_value   <= result;
            r_swapped <= (r_mode == OP_CAS) && cas_match;
        end
    end

    assign o_value   = r_value;
    assign o_swapped = r_swapped;

endmodule

// File: hw/rtl/atomic_memory_op_unit.sv
// ----------------------------------------------------------------------------
// Atomic memory operation unit
// Indivisible read-modify-write on byte, halfword and word lanes of a
// word store, with fetch-and-op, exchange and compare-and-swap.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis channel, one per transaction, and each
//   produces exactly one response on the m_axis channel, in order.
//   A request goes through three steps: accept, read of the addressed word
//   from the store, then modify and write-back with the response loaded
//   into the output register. A new request is taken only once the last
//   one has left the write-back step; the controller accepts only when idle.
//   m_axis_tvalid comes from the output register loaded at write-back.
//   The response sits in a register, so the next request is accepted while
//   it waits; a request reaching the write-back step holds there while the
//   output register is still full and not being taken.
//   After reset the store is cleared to zero one word per cycle, and
//   s_axis_tready stays low until that pass is done.
//   Word indexes wrap modulo STORE_WORDS.
// ----------------------------------------------------------------------------
module atomic_memory_op_unit
    import amo_pkg::*;
#(
    parameter int STORE_WORDS = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // Fields from bit 0: mode[3], size[2], return_new[1], byte_address[12],
    // operand[32], expected[32], zero fill.
    input  logic [REQ_TDATA_W-1:0] s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // Fields from bit 0: value[32], swapped[1], zero fill.
    output logic [RSP_TDATA_W-1:0] m_axis_tdata
);

    t_amo_cmd          cmd;
    t_amo_sts          sts;
    logic [DATA_W-1:0] value;
    logic              swapped;

    amo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .o_rsp_valid (m_axis_tvalid),
        .i_rsp_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    amo_dp #(
        .STORE_WORDS (STORE_WORDS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_data (s_axis_tdata),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_value    (value),
        .o_swapped  (swapped)
    );

    // Pack the response with zero fill to a whole byte.
    assign m_axis_tdata = {(RSP_TDATA_W - RSP_BITS)'(0), swapped, value};

endmodule
